// File: rtl/bb3s_pkg.sv
// Shared types and constants for the streaming 3x3 box blur.
// No dependencies; used by the core, its RAM instances' users and the port checker.
package bb3s_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 12;
    localparam int MEAN_W  = 12;
    localparam int COORD_W = 8;
    localparam int CSUM_W  = 10;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

    // mean = floor((16*sum + 4) / 9) = (y * RECIP9) >> RECIP_SHIFT for y < 2^16
    localparam int DIVIN_W = 16;
    localparam int PROD_W  = 32;
    localparam int RECIP_SHIFT = 19;
    localparam logic [DIVIN_W-1:0] RECIP9 = 16'd58255;
    localparam logic [DIVIN_W-1:0] ROUND_BIAS = 16'd4;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_value;
        logic [SUM_W-1:0]   window_sum;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               frame_last;
    } t_result;

endpackage

// File: rtl/bb3s_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bb3s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 258
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/box_blur_3x3_stream_core.sv
// Streaming 3x3 box blur core: two line-store RAMs, column-sum window, divide-by-9 pipe.
// Depends on bb3s_pkg and bb3s_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one padded pixel per item in
//   raster order over a (out_width+2) x (out_height+2) frame; i_frame_start marks
//   padded pixel (0,0). Output channel (o_out_valid / i_out_stall) carries one
//   result per interior pixel: 3x3 sum, rounded mean in 8.4, output coordinates
//   and a flag on the last pixel of the frame.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 = out_width,
//   1 = out_height); the user writes only while the block is idle, which the core does not enforce.
//   Throughput: one item per cycle while o_in_stall is low. o_out_valid rises once
//   an accepted item has passed the window update, sum, multiply and result queue
//   write; the line-store read takes the accepting edge itself.
//   Reset: position returns to (0,0), window sums clear, sizes return to 256,
//   the result queue empties. Line stores are not cleared.
//   Stall: results collect in an 8-entry queue; input keeps flowing until the
//   queue plus the items in the pipe reach its depth, then o_in_stall rises.
module box_blur_3x3_stream_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bb3s_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bb3s_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bb3s_pkg::PIX_W-1:0]          i_pixel,
    input  logic                                i_frame_start,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bb3s_pkg::MEAN_W-1:0]         o_mean_value,
    output logic [bb3s_pkg::SUM_W-1:0]          o_window_sum,
    output logic [bb3s_pkg::COORD_W-1:0]        o_out_col,
    output logic [bb3s_pkg::COORD_W-1:0]        o_out_row,
    output logic                                o_frame_last
);

    localparam int COL_W = ($clog2(MAX_WIDTH + 3) > 10) ? $clog2(MAX_WIDTH + 3) : 10;
    localparam int ROW_W = ($clog2(MAX_HEIGHT + 3) > 10) ? $clog2(MAX_HEIGHT + 3) : 10;
    localparam int STORE_DEPTH = MAX_WIDTH + 2;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam int PIX_W  = bb3s_pkg::PIX_W;
    localparam int CSUM_W = bb3s_pkg::CSUM_W;
    localparam int SUM_W  = bb3s_pkg::SUM_W;
    localparam int CRD_W  = bb3s_pkg::COORD_W;

    // configuration
    logic [bb3s_pkg::CFG_DATA_W-1:0] r_out_width, r_out_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= bb3s_pkg::DIM_RESET;
            r_out_height <= bb3s_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bb3s_pkg::CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                bb3s_pkg::CFG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                default:                  r_out_width  <= r_out_width;
            endcase
        end
    end

    logic [COL_W-1:0] w_ext, pw;
    logic [ROW_W-1:0] h_ext, ph;

    always_comb begin
        w_ext = COL_W'(r_out_width);
        h_ext = ROW_W'(r_out_height);
        if (w_ext == '0) begin
            pw = COL_W'(3);
        end else if (w_ext > COL_W'(MAX_WIDTH)) begin
            pw = COL_W'(MAX_WIDTH + 2);
        end else begin
            pw = w_ext + COL_W'(2);
        end
        if (h_ext == '0) begin
            ph = ROW_W'(3);
        end else if (h_ext > ROW_W'(MAX_HEIGHT)) begin
            ph = ROW_W'(MAX_HEIGHT + 2);
        end else begin
            ph = h_ext + ROW_W'(2);
        end
    end

    // result queue occupancy and input flow control
    logic [bb3s_pkg::FIFO_CNT_W-1:0] r_cnt;
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic [bb3s_pkg::FIFO_CNT_W-1:0] occupancy;
    logic in_accept;

    assign occupancy = r_cnt + bb3s_pkg::FIFO_CNT_W'(r_s1_valid)
                     + bb3s_pkg::FIFO_CNT_W'(r_s2_valid)
                     + bb3s_pkg::FIFO_CNT_W'(r_s3_valid)
                     + bb3s_pkg::FIFO_CNT_W'(r_s4_valid);
    assign o_in_stall = (occupancy >= bb3s_pkg::FIFO_CNT_W'(bb3s_pkg::FIFO_DEPTH));
    assign in_accept  = i_in_valid && !o_in_stall;

    // position of the accepted pixel
    logic [COL_W-1:0] r_col, col_a, col_c, col_inc, n_col;
    logic [ROW_W-1:0] r_row, row_a, row_b, row_c, row_inc, n_row;
    logic             emit, last;

    always_comb begin
        col_a = i_frame_start ? '0 : r_col;
        row_a = i_frame_start ? '0 : r_row;
        if (col_a >= pw) begin
            col_c = '0;
            row_b = row_a + ROW_W'(1);
        end else begin
            col_c = col_a;
            row_b = row_a;
        end
        row_c = (row_b >= ph) ? '0 : row_b;

        col_inc = col_c + COL_W'(1);
        row_inc = row_c + ROW_W'(1);
        if (col_inc >= pw) begin
            n_col = '0;
            n_row = (row_inc >= ph) ? '0 : row_inc;
        end else begin
            n_col = col_inc;
            n_row = row_c;
        end

        emit = (col_c >= COL_W'(2)) && (row_c >= ROW_W'(2));
        last = (col_c == pw - COL_W'(1)) && (row_c == ph - ROW_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line-store read data arrives
    logic [PIX_W-1:0]  r_s1_px;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_emit, r_s1_last;
    logic [CRD_W-1:0]  r_s1_col, r_s1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
        r_s1_px   <= i_pixel;
        r_s1_addr <= col_c[ADDR_W-1:0];
        r_s1_emit <= emit;
        r_s1_last <= last;
        r_s1_col  <= CRD_W'(col_c - COL_W'(2));
        r_s1_row  <= CRD_W'(row_c - ROW_W'(2));
    end

    logic [PIX_W-1:0] upper_rdata, middle_rdata, top_px, mid_px;
    logic             r_fw_valid;
    logic [ADDR_W-1:0] r_fw_addr;
    logic [PIX_W-1:0] r_fw_top, r_fw_mid;

    bb3s_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (mid_px),
        .i_raddr (col_c[ADDR_W-1:0]),
        .o_rdata (upper_rdata)
    );

    bb3s_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_px),
        .i_raddr (col_c[ADDR_W-1:0]),
        .o_rdata (middle_rdata)
    );

    // forward the write that landed on the same edge as this item's read
    always_comb begin
        if (r_fw_valid && (r_fw_addr == r_s1_addr)) begin
            top_px = r_fw_top;
            mid_px = r_fw_mid;
        end else begin
            top_px = upper_rdata;
            mid_px = middle_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= r_s1_valid;
        end
        r_fw_addr <= r_s1_addr;
        r_fw_top  <= mid_px;
        r_fw_mid  <= r_s1_px;
    end

    // window held as three column sums, oldest first
    logic [CSUM_W-1:0] r_cs0, r_cs1, r_cs2, cs_new;

    assign cs_new = CSUM_W'(top_px) + CSUM_W'(mid_px) + CSUM_W'(r_s1_px);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs0 <= '0;
            r_cs1 <= '0;
            r_cs2 <= '0;
        end else if (r_s1_valid) begin
            r_cs0 <= r_cs1;
            r_cs1 <= r_cs2;
            r_cs2 <= cs_new;
        end
    end

    // stages 2..4: sum, multiply by reciprocal of 9
    logic             r_s2_last, r_s3_last, r_s4_last;
    logic [CRD_W-1:0] r_s2_col, r_s2_row, r_s3_col, r_s3_row, r_s4_col, r_s4_row;
    logic [SUM_W-1:0] r_s3_sum, r_s4_sum;
    logic [bb3s_pkg::DIVIN_W-1:0] div_in;
    logic [bb3s_pkg::PROD_W-1:0]  r_s4_prod;

    assign div_in = {r_s3_sum, 4'd0} + bb3s_pkg::ROUND_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
        r_s2_last <= r_s1_last;
        r_s2_col  <= r_s1_col;
        r_s2_row  <= r_s1_row;
        r_s3_sum  <= SUM_W'(r_cs0) + SUM_W'(r_cs1) + SUM_W'(r_cs2);
        r_s3_last <= r_s2_last;
        r_s3_col  <= r_s2_col;
        r_s3_row  <= r_s2_row;
        r_s4_prod <= bb3s_pkg::PROD_W'(div_in) * bb3s_pkg::PROD_W'(bb3s_pkg::RECIP9);
        r_s4_sum  <= r_s3_sum;
        r_s4_last <= r_s3_last;
        r_s4_col  <= r_s3_col;
        r_s4_row  <= r_s3_row;
    end

    // result queue
    bb3s_pkg::t_result r_fifo [bb3s_pkg::FIFO_DEPTH];
    bb3s_pkg::t_result push_data, head;
    logic [bb3s_pkg::FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic push, pop;

    always_comb begin
        push_data.mean_value = r_s4_prod[bb3s_pkg::RECIP_SHIFT +: bb3s_pkg::MEAN_W];
        push_data.window_sum = r_s4_sum;
        push_data.out_col    = r_s4_col;
        push_data.out_row    = r_s4_row;
        push_data.frame_last = r_s4_last;
    end

    assign push = r_s4_valid;
    assign pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + bb3s_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + bb3s_pkg::FIFO_PTR_W'(1);
            end
            r_cnt <= r_cnt + bb3s_pkg::FIFO_CNT_W'(push) - bb3s_pkg::FIFO_CNT_W'(pop);
        end
        if (push) begin
            r_fifo[r_wr_ptr] <= push_data;
        end
    end

    assign head         = r_fifo[r_rd_ptr];
    assign o_out_valid  = (r_cnt != '0);
    assign o_mean_value = head.mean_value;
    assign o_window_sum = head.window_sum;
    assign o_out_col    = head.out_col;
    assign o_out_row    = head.out_row;
    assign o_frame_last = head.frame_last;

endmodule

// File: rtl/bb3s_checker.sv
// Port-level checker for the streaming 3x3 box blur core, bound to the top level.
// Depends on bb3s_pkg and box_blur_3x3_stream_core.
module bb3s_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [bb3s_pkg::MEAN_W-1:0]     o_mean_value,
    input logic [bb3s_pkg::SUM_W-1:0]      o_window_sum,
    input logic [bb3s_pkg::COORD_W-1:0]    o_out_col,
    input logic [bb3s_pkg::COORD_W-1:0]    o_out_row,
    input logic                            o_frame_last
);

    logic [16:0] mean9, sum16;

    assign mean9 = {5'd0, o_mean_value} * 17'd9;
    assign sum16 = {1'b0, o_window_sum, 4'd0};

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mean_value)
            && $stable(o_window_sum) && $stable(o_out_col) && $stable(o_out_row)
            && $stable(o_frame_last))
        else $error("result changed while stalled");

    a_mean_rounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (mean9 + 17'd4 >= sum16) && (mean9 <= sum16 + 17'd4))
        else $error("mean is not the rounded sum over nine");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_window_sum <= 12'd2295)
        else $error("window sum out of range");

    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result shown right after reset");

endmodule

bind box_blur_3x3_stream_core bb3s_checker u_bb3s_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_mean_value (o_mean_value),
    .o_window_sum (o_window_sum),
    .o_out_col    (o_out_col),
    .o_out_row    (o_out_row),
    .o_frame_last (o_frame_last)
);
